/* rtl/aes_ctr_pkg.sv */
// Package for the AES-256 CTR cipher unit: payload types, constants, S-box
// and round helper functions. No dependencies.
`default_nettype none
package aes_ctr_pkg;

   localparam int unsigned NumRounds    = 14;
   localparam int unsigned RoundWidth   = 4;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 64;
   localparam logic [4:0]  MaxBytes     = 5'd16;

   localparam logic [CsrIdxWidth-1:0] RegKey0   = 3'd0;
   localparam logic [CsrIdxWidth-1:0] RegKey1   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] RegKey2   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] RegKey3   = 3'd3;
   localparam logic [CsrIdxWidth-1:0] RegIvHigh = 3'd4;
   localparam logic [CsrIdxWidth-1:0] RegIvLow  = 3'd5;

   typedef struct packed {
      logic        start_req;
      logic [63:0] data_high;
      logic [63:0] data_low;
      logic [4:0]  valid_bytes;
   } req_type;

   typedef struct packed {
      logic [63:0] out_high;
      logic [63:0] out_low;
      logic [4:0]  out_bytes;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_start;   // latch request, snapshot key, reload counter
      logic load_item;    // latch request without start
      logic init_round;   // counter xor round key 0
      logic round_step;   // one cipher round
      logic last_round;
      logic finish;       // build result, advance counter
   } dp_cmd_type;

   typedef struct packed {
      logic [RoundWidth-1:0]  round;
   } dp_idx_type;

   localparam logic [7:0] SboxTab [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SboxTab[w[31:24]], SboxTab[w[23:16]], SboxTab[w[15:8]], SboxTab[w[7:0]]};
   endfunction

   // state byte i (0 = first) sits at bits [127-8i -: 8]
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(4*c+r) -: 8] = SboxTab[s[127-8*(4*((c+r)%4)+r) -: 8]];
         end
      end
      sub_shift = t;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3, all;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0  = s[127-32*c -: 8];
         a1  = s[119-32*c -: 8];
         a2  = s[111-32*c -: 8];
         a3  = s[103-32*c -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         t[127-32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         t[119-32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         t[111-32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[103-32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      mix_columns = t;
   endfunction

endpackage
`default_nettype wire

/* rtl/aes_ctr_ctrl.sv */
// Controller for the AES-256 CTR unit: sequences the rounds and the result
// handshake. Depends on aes_ctr_pkg.
`default_nettype none
module aes_ctr_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_start,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output aes_ctr_pkg::dp_cmd_type     cmd,
   output aes_ctr_pkg::dp_idx_type     idx
);
   typedef enum logic [1:0] {IDLE, INIT, ROUND, FIN} state_type;

   state_type state_ff, state_in;
   logic [aes_ctr_pkg::RoundWidth-1:0]  rnd_ff, rnd_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   // next item may enter while the previous result still waits
   assign req_ready = (state_ff == IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rnd_in       = rnd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               cmd.load_start = req_start;
               cmd.load_item  = !req_start;
               state_in       = INIT;
            end
         end
         INIT: begin
            cmd.init_round = 1'b1;
            rnd_in         = 4'd1;
            state_in       = ROUND;
         end
         ROUND: begin
            cmd.round_step = 1'b1;
            cmd.last_round = (rnd_ff == 4'(aes_ctr_pkg::NumRounds));
            rnd_in         = rnd_ff + 4'd1;
            if (cmd.last_round) state_in = FIN;
         end
         FIN: begin
            // hold here while the previous result is still unaccepted
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
      idx.round = rnd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/aes_ctr_dp.sv */
// Datapath for the AES-256 CTR unit: config registers, key schedule,
// counter, cipher state and result register. Depends on aes_ctr_pkg.
`default_nettype none
module aes_ctr_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write,
   input  wire logic [aes_ctr_pkg::CsrIdxWidth-1:0]   csr_index,
   input  wire logic [aes_ctr_pkg::CsrDataWidth-1:0]  csr_data,
   input  wire aes_ctr_pkg::req_type                  req_data,
   input  wire aes_ctr_pkg::dp_cmd_type               cmd,
   input  wire aes_ctr_pkg::dp_idx_type               idx,
   output aes_ctr_pkg::rsp_type                       rsp_data
);
   logic [63:0]  key_ff [4];
   logic [63:0]  iv_high_ff, iv_low_ff;
   // key words 0..7 captured at start; round keys are regenerated from it for
   // every block, window holds words 4r..4r+7 during round r
   logic [255:0] kbase_ff, win_ff, win_in;
   logic [127:0] ctr_ff, st_ff, st_in;
   aes_ctr_pkg::req_type  item_ff;
   aes_ctr_pkg::rsp_type  rsp_ff;
   logic [31:0]  t, lastw, n0, n1, n2, n3;
   logic         odd_step;
   logic [7:0]   rc_ff;
   logic [127:0] rkey, sm, res;
   logic [4:0]   n;

   // next four schedule words; the first one is word 4r+8
   always_comb begin
      odd_step = cmd.round_step && idx.round[0];
      lastw    = win_ff[31:0];
      if (odd_step)
         t = aes_ctr_pkg::sub_word(lastw);
      else
         t = aes_ctr_pkg::sub_word({lastw[23:0], lastw[31:24]}) ^ {rc_ff, 24'h0};
      n0     = win_ff[255:224] ^ t;
      n1     = win_ff[223:192] ^ n0;
      n2     = win_ff[191:160] ^ n1;
      n3     = win_ff[159:128] ^ n2;
      win_in = {win_ff[127:0], n0, n1, n2, n3};
   end

   always_comb begin
      rkey = win_ff[255:128];
      sm   = aes_ctr_pkg::sub_shift(st_ff);
      if (!cmd.last_round) sm = aes_ctr_pkg::mix_columns(sm);
      st_in = cmd.init_round ? (ctr_ff ^ rkey) : (sm ^ rkey);
      n = (item_ff.valid_bytes > aes_ctr_pkg::MaxBytes) ? aes_ctr_pkg::MaxBytes
                                                       : item_ff.valid_bytes;
      res = {item_ff.data_high, item_ff.data_low} ^ st_ff;
      for (int i = 0; i < 16; i++) begin
         if (5'(i) >= n) res[127-8*i -: 8] = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0]  <= '0;
         key_ff[1]  <= '0;
         key_ff[2]  <= '0;
         key_ff[3]  <= '0;
         iv_high_ff <= '0;
         iv_low_ff  <= '0;
         ctr_ff     <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               aes_ctr_pkg::RegKey0:   key_ff[0]  <= csr_data;
               aes_ctr_pkg::RegKey1:   key_ff[1]  <= csr_data;
               aes_ctr_pkg::RegKey2:   key_ff[2]  <= csr_data;
               aes_ctr_pkg::RegKey3:   key_ff[3]  <= csr_data;
               aes_ctr_pkg::RegIvHigh: iv_high_ff <= csr_data;
               aes_ctr_pkg::RegIvLow:  iv_low_ff  <= csr_data;
               default: ;
            endcase
         end
         if (cmd.load_start) ctr_ff <= {iv_high_ff, iv_low_ff};
         else if (cmd.finish) ctr_ff <= ctr_ff + 128'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_start || cmd.load_item) item_ff <= req_data;
      if (cmd.load_start) begin
         kbase_ff <= {key_ff[0], key_ff[1], key_ff[2], key_ff[3]};
         win_ff   <= {key_ff[0], key_ff[1], key_ff[2], key_ff[3]};
         rc_ff    <= 8'h01;
      end else if (cmd.load_item) begin
         win_ff <= kbase_ff;
         rc_ff  <= 8'h01;
      end else if (cmd.init_round || cmd.round_step) begin
         win_ff <= win_in;
         if (!odd_step) rc_ff <= aes_ctr_pkg::xtime(rc_ff);
      end
      if (cmd.init_round || cmd.round_step) st_ff <= st_in;
      if (cmd.finish) begin
         rsp_ff.out_high  <= res[127:64];
         rsp_ff.out_low   <= res[63:0];
         rsp_ff.out_bytes <= n;
      end
   end

   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

/* rtl/aes256_ctr_cipher_unit.sv */
// AES-256 counter-mode cipher unit, top level.
// Depends on aes_ctr_pkg, aes_ctr_ctrl and aes_ctr_dp.
//
// Usage: write key_0..key_3, iv_high and iv_low through the csr_ port while
// idle. Send 16-byte blocks on the req_ channel (valid/ready); set start_req
// on the first block of a message to capture the key and load the counter.
// Each transaction returns one result on the rsp_ channel: data xor
// keystream, bytes past valid_bytes cleared, count above 16 saturated.
// After acceptance a block passes the initial key add, 14 rounds and the
// result register before rsp_valid; round keys are generated alongside the
// rounds, four words per cycle, so a start block takes no longer than others.
// One round per cycle through a single round unit; a new block is accepted
// only after the controller has finished the previous one and returned to idle.
// Reset clears the counter, config registers and handshake state; round
// keys are undefined until the first start. When the receiver stalls the
// result holds in its register and the next block may still be accepted and
// worked on; it completes once the held result is taken.
`default_nettype none
module aes256_ctr_cipher_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write,
   input  wire logic [aes_ctr_pkg::CsrIdxWidth-1:0]   csr_index,
   input  wire logic [aes_ctr_pkg::CsrDataWidth-1:0]  csr_data,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire aes_ctr_pkg::req_type                  req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output aes_ctr_pkg::rsp_type                       rsp_data
);
   aes_ctr_pkg::dp_cmd_type cmd;
   aes_ctr_pkg::dp_idx_type idx;

   aes_ctr_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready,
      .req_start(req_data.start_req), .rsp_valid, .rsp_ready, .cmd, .idx
   );

   aes_ctr_dp u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_data, .cmd, .idx, .rsp_data
   );
endmodule
`default_nettype wire
